/* design/tli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants of the table interpolator
// Sequencer states, shared arithmetic unit request and response types,
// status codes and register indexes.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int DATA_W        = 32;
    localparam int MAG_W         = DATA_W + 1;
    localparam int ROW_W         = 3 * DATA_W;
    localparam int ENTRY_COUNT_W = 9;
    localparam int INDEX_W       = 8;
    localparam int STATUS_W      = 3;
    localparam int PADDR_W       = 3;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXTRAP     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_WIDTH = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_SMALL  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED  = 3'd4;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_RD0,
        ST_RDN,
        ST_RDA,
        ST_RDB,
        ST_PREP,
        ST_DIV,
        ST_MUL1,
        ST_MUL2
    } t_state;

    typedef enum logic {
        ALU_DIV,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic busy;
    } t_alu_rsp;

endpackage

/* design/tli_table_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_table_ram: breakpoint table storage
// One row per entry holding x, y1 and y2. One write port and one read port
// with registered read data.
// ----------------------------------------------------------------------------
module tli_table_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 96
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tli_shift_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_shift_unit: shared shift-and-add arithmetic unit
// One adder serves a restoring divider (one quotient bit per cycle) and a
// shift-add multiplier (one multiplier bit per cycle).
// ----------------------------------------------------------------------------
module tli_shift_unit #(
    parameter int A_W = 49,
    parameter int B_W = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tli_pkg::t_alu_req    i_req,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output tli_pkg::t_alu_rsp    o_rsp,
    output logic [A_W-1:0]       o_quotient,
    output logic [A_W+B_W-1:0]   o_product
);

    localparam int W   = A_W + 1;
    localparam int C_W = $clog2(A_W + 1);

    tli_pkg::t_alu_op r_op;
    logic [C_W-1:0]   r_cnt;
    logic             r_done;
    // r_a: numerator/quotient for divide, multiplicand for multiply.
    // r_lo: divisor for divide, multiplier/low product bits for multiply.
    logic [W-1:0]     r_acc;
    logic [A_W-1:0]   r_a;
    logic [B_W-1:0]   r_lo;

    logic [B_W:0]     w_rem_sh;
    logic [W:0]       w_add_x;
    logic [W:0]       w_add_y;
    logic             w_cin;
    logic [W:0]       w_sum;

    always_comb begin
        w_rem_sh = {r_acc[B_W-1:0], r_a[A_W-1]};
        if (r_op == tli_pkg::ALU_DIV) begin
            w_add_x = (W+1)'(w_rem_sh);
            w_add_y = ~((W+1)'(r_lo));
            w_cin   = 1'b1;
        end else begin
            w_add_x = {1'b0, r_acc};
            w_add_y = r_lo[0] ? (W+1)'(r_a) : '0;
            w_cin   = 1'b0;
        end
        w_sum = w_add_x + w_add_y + (W+1)'(w_cin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= tli_pkg::ALU_DIV;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op  <= i_req.op;
                r_cnt <= (i_req.op == tli_pkg::ALU_DIV) ? C_W'(A_W) : C_W'(B_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - C_W'(1);
                r_done <= (r_cnt == C_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_lo  <= i_b;
        end else if (r_cnt != '0) begin
            if (r_op == tli_pkg::ALU_DIV) begin
                // A clear sign bit means the shifted remainder covers the divisor.
                if (!w_sum[W]) begin
                    r_acc <= {{(W-B_W){1'b0}}, w_sum[B_W-1:0]};
                end else begin
                    r_acc <= {{(W-B_W){1'b0}}, w_rem_sh[B_W-1:0]};
                end
                r_a <= {r_a[A_W-2:0], ~w_sum[W]};
            end else begin
                r_acc <= w_sum[W:1];
                r_lo  <= {w_sum[0], r_lo[B_W-1:1]};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = (r_cnt != '0);
    assign o_quotient = r_a;
    assign o_product  = {r_acc[A_W-1:0], r_lo};

endmodule

/* design/table_linear_interpolator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linear_interpolator_core: two-column piecewise linear table lookup
// Loads breakpoint rows and answers queries by bisection search, an
// iterative weight division and two shift-add multiplications.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  input     start / busy              i_action, i_entry_index, i_x_value,
//                                      i_y1_value, i_y2_value
//  result    o_done (one-cycle strobe) o_y1_result, o_y2_result, o_status
//  config    APB psel/penable/pwrite   entry_count at byte address 0
//
//  A load word is written in the cycle it is accepted; busy stays low.
//  A query runs a bisection search, reads the first and last rows and the
//  two segment rows, then, unless the segment has zero width, divides once
//  and multiplies twice in the shared unit, which makes one bit per cycle.
//  Tables too small answer in the next cycle. Reset clears the sequencer,
//  the strobe and entry_count; the table is not cleared. The receiver cannot
//  stall, so o_done marks each result for one cycle.
// ----------------------------------------------------------------------------
module table_linear_interpolator_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_action,
    input  logic [tli_pkg::INDEX_W-1:0]          i_entry_index,
    input  logic signed [tli_pkg::DATA_W-1:0]    i_x_value,
    input  logic signed [tli_pkg::DATA_W-1:0]    i_y1_value,
    input  logic signed [tli_pkg::DATA_W-1:0]    i_y2_value,
    output logic                                 o_done,
    output logic signed [tli_pkg::DATA_W-1:0]    o_y1_result,
    output logic signed [tli_pkg::DATA_W-1:0]    o_y2_result,
    output logic [tli_pkg::STATUS_W-1:0]         o_status,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tli_pkg::PADDR_W-1:0]          paddr,
    input  logic [tli_pkg::DATA_W-1:0]           pwdata,
    output logic [tli_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);

    localparam int DW  = tli_pkg::DATA_W;
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = ($clog2(TABLE_DEPTH + 1) > tli_pkg::ENTRY_COUNT_W) ?
                         $clog2(TABLE_DEPTH + 1) : tli_pkg::ENTRY_COUNT_W;
    localparam int QW  = tli_pkg::MAG_W + FRAC_BITS;
    localparam int PW  = QW + tli_pkg::MAG_W;
    localparam int RW  = tli_pkg::ROW_W;

    // Entry index wrapped to the table depth by conditional subtraction.
    function automatic logic [AW-1:0] f_wrap(input logic [tli_pkg::INDEX_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        for (int s = tli_pkg::INDEX_W - 1; s >= 0; s--) begin
            if (t >= (32'(TABLE_DEPTH) << s)) begin
                t = t - (32'(TABLE_DEPTH) << s);
            end
        end
        return t[AW-1:0];
    endfunction

    // Sign and magnitude of a - b for two signed words.
    function automatic logic [tli_pkg::MAG_W:0] f_abs_diff(input logic [DW-1:0] a,
                                                           input logic [DW-1:0] b);
        logic [tli_pkg::MAG_W-1:0] d;
        d = {a[DW-1], a} - {b[DW-1], b};
        return {d[tli_pkg::MAG_W-1],
                d[tli_pkg::MAG_W-1] ? (~d + tli_pkg::MAG_W'(1)) : d};
    endfunction

    // y_b plus or minus the scaled product, clipped to a signed word.
    // Returns the clip flag above the result word.
    function automatic logic [DW:0] f_sat(input logic [DW-1:0] yb,
                                          input logic [PW-1:0] prod,
                                          input logic neg);
        logic                             big;
        logic [tli_pkg::MAG_W-1:0]        q;
        logic signed [tli_pkg::MAG_W+1:0] s;
        logic signed [tli_pkg::MAG_W+1:0] qs;
        big = |prod[PW-1:FRAC_BITS+tli_pkg::MAG_W];
        q   = prod[FRAC_BITS+tli_pkg::MAG_W-1:FRAC_BITS];
        qs  = $signed({2'b00, q});
        s   = $signed({{3{yb[DW-1]}}, yb}) + (neg ? -qs : qs);
        if (big) begin
            return {1'b1, neg ? tli_pkg::SAT_MIN : tli_pkg::SAT_MAX};
        end else if (s > $signed({3'b000, tli_pkg::SAT_MAX})) begin
            return {1'b1, tli_pkg::SAT_MAX};
        end else if (s < $signed({3'b111, tli_pkg::SAT_MIN})) begin
            return {1'b1, tli_pkg::SAT_MIN};
        end
        return {1'b0, s[DW-1:0]};
    endfunction

    tli_pkg::t_state r_state, n_state;
    logic            r_done, n_done;
    logic [tli_pkg::ENTRY_COUNT_W-1:0] r_entry_count;

    logic signed [DW-1:0] r_x, n_x;
    logic [CW-1:0]        r_n, n_n;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_j, n_j;
    logic                 r_ext, n_ext;
    logic [RW-1:0]        r_row_a, n_row_a;
    logic [RW-1:0]        r_row_b, n_row_b;
    logic                 r_wneg, n_wneg;
    logic                 r_pneg, n_pneg;
    logic [QW-1:0]        r_wmag, n_wmag;
    logic                 r_sat, n_sat;
    logic [DW-1:0]        r_y1o, n_y1o;
    logic [DW-1:0]        r_y2o, n_y2o;
    logic [tli_pkg::STATUS_W-1:0] r_statuso, n_statuso;

    logic                 w_accept;
    logic                 w_we;
    logic [AW-1:0]        w_raddr;
    logic [RW-1:0]        w_rdata;
    logic [CW-1:0]        w_count_ext;
    logic [CW-1:0]        w_n;
    logic [CW-1:0]        w_half;
    logic                 w_lt;
    logic [CW-1:0]        w_ni, w_nj, w_mid, w_nm1, w_nm2, w_ip1;
    logic [CW:0]          w_mid_sum;
    logic [tli_pkg::MAG_W:0] w_nd, w_dd, w_dy1, w_dy2;
    logic [DW:0]          w_sat;

    tli_pkg::t_alu_req    w_alu_req;
    tli_pkg::t_alu_rsp    w_alu_rsp;
    logic [QW-1:0]        w_alu_a;
    logic [tli_pkg::MAG_W-1:0] w_alu_b;
    logic [QW-1:0]        w_quotient;
    logic [PW-1:0]        w_product;

    assign w_accept = start && !busy;
    assign w_we     = w_accept && (i_action == tli_pkg::ACTION_LOAD);
    assign busy     = (r_state != tli_pkg::ST_IDLE);

    tli_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (RW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (f_wrap(i_entry_index)),
        .i_wdata ({i_x_value, i_y1_value, i_y2_value}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tli_shift_unit #(
        .A_W (QW),
        .B_W (tli_pkg::MAG_W)
    ) u_alu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_alu_req),
        .i_a        (w_alu_a),
        .i_b        (w_alu_b),
        .o_rsp      (w_alu_rsp),
        .o_quotient (w_quotient),
        .o_product  (w_product)
    );

    always_comb begin
        w_count_ext = CW'(r_entry_count);
        w_n         = (w_count_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : w_count_ext;
        w_half      = w_n >> 1;
        w_lt        = $signed(w_rdata[RW-1:RW-DW]) < r_x;
        w_mid_sum   = ({1'b0, r_i} + {1'b0, r_j}) >> 1;
        w_ni        = w_lt ? w_mid_sum[CW-1:0] : r_i;
        w_nj        = w_lt ? r_j : w_mid_sum[CW-1:0];
        w_mid_sum   = ({1'b0, w_ni} + {1'b0, w_nj}) >> 1;
        w_mid       = w_mid_sum[CW-1:0];
        w_nm1       = r_n - CW'(1);
        w_nm2       = r_n - CW'(2);
        w_ip1       = r_i + CW'(1);
        w_nd        = f_abs_diff(r_row_b[RW-1:RW-DW], r_x);
        w_dd        = f_abs_diff(r_row_b[RW-1:RW-DW], r_row_a[RW-1:RW-DW]);
        w_dy1       = f_abs_diff(r_row_a[2*DW-1:DW], r_row_b[2*DW-1:DW]);
        w_dy2       = f_abs_diff(r_row_a[DW-1:0], r_row_b[DW-1:0]);
        w_sat       = f_sat((r_state == tli_pkg::ST_MUL1) ? r_row_b[2*DW-1:DW]
                                                          : r_row_b[DW-1:0],
                            w_product, r_pneg);
    end

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_x       = r_x;
        n_n       = r_n;
        n_i       = r_i;
        n_j       = r_j;
        n_ext     = r_ext;
        n_row_a   = r_row_a;
        n_row_b   = r_row_b;
        n_wneg    = r_wneg;
        n_pneg    = r_pneg;
        n_wmag    = r_wmag;
        n_sat     = r_sat;
        n_y1o     = r_y1o;
        n_y2o     = r_y2o;
        n_statuso = r_statuso;
        w_raddr   = '0;
        w_alu_req = '{start: 1'b0, op: tli_pkg::ALU_DIV};
        w_alu_a   = '0;
        w_alu_b   = '0;

        case (r_state)
            tli_pkg::ST_IDLE: begin
                w_raddr = w_half[AW-1:0];
                if (w_accept && (i_action == tli_pkg::ACTION_QUERY)) begin
                    if (w_n < CW'(2)) begin
                        n_done    = 1'b1;
                        n_y1o     = '0;
                        n_y2o     = '0;
                        n_statuso = tli_pkg::STATUS_TOO_SMALL;
                    end else begin
                        n_x     = i_x_value;
                        n_n     = w_n;
                        n_i     = '0;
                        n_j     = w_n;
                        n_state = tli_pkg::ST_SRCH;
                    end
                end
            end
            tli_pkg::ST_SRCH: begin
                // Read data belongs to the midpoint of the current bounds.
                n_i = w_ni;
                n_j = w_nj;
                if ((w_nj - w_ni) > CW'(1)) begin
                    w_raddr = w_mid[AW-1:0];
                end else begin
                    n_i     = (w_ni > w_nm2) ? w_nm2 : w_ni;
                    w_raddr = '0;
                    n_state = tli_pkg::ST_RD0;
                end
            end
            tli_pkg::ST_RD0: begin
                n_ext   = r_x < $signed(w_rdata[RW-1:RW-DW]);
                w_raddr = w_nm1[AW-1:0];
                n_state = tli_pkg::ST_RDN;
            end
            tli_pkg::ST_RDN: begin
                n_ext   = r_ext || (r_x > $signed(w_rdata[RW-1:RW-DW]));
                w_raddr = r_i[AW-1:0];
                n_state = tli_pkg::ST_RDA;
            end
            tli_pkg::ST_RDA: begin
                n_row_a = w_rdata;
                w_raddr = w_ip1[AW-1:0];
                n_state = tli_pkg::ST_RDB;
            end
            tli_pkg::ST_RDB: begin
                n_row_b = w_rdata;
                n_state = tli_pkg::ST_PREP;
            end
            tli_pkg::ST_PREP: begin
                if (r_row_a[RW-1:RW-DW] == r_row_b[RW-1:RW-DW]) begin
                    n_done    = 1'b1;
                    n_y1o     = r_row_a[2*DW-1:DW];
                    n_y2o     = r_row_a[DW-1:0];
                    n_statuso = tli_pkg::STATUS_ZERO_WIDTH;
                    n_state   = tli_pkg::ST_IDLE;
                end else begin
                    w_alu_req = '{start: 1'b1, op: tli_pkg::ALU_DIV};
                    w_alu_a   = {w_nd[tli_pkg::MAG_W-1:0], {FRAC_BITS{1'b0}}};
                    w_alu_b   = w_dd[tli_pkg::MAG_W-1:0];
                    n_wneg    = w_nd[tli_pkg::MAG_W] ^ w_dd[tli_pkg::MAG_W];
                    n_sat     = 1'b0;
                    n_state   = tli_pkg::ST_DIV;
                end
            end
            tli_pkg::ST_DIV: begin
                if (w_alu_rsp.done) begin
                    n_wmag    = w_quotient;
                    w_alu_req = '{start: 1'b1, op: tli_pkg::ALU_MUL};
                    w_alu_a   = w_quotient;
                    w_alu_b   = w_dy1[tli_pkg::MAG_W-1:0];
                    n_pneg    = r_wneg ^ w_dy1[tli_pkg::MAG_W];
                    n_state   = tli_pkg::ST_MUL1;
                end
            end
            tli_pkg::ST_MUL1: begin
                if (w_alu_rsp.done) begin
                    n_y1o     = w_sat[DW-1:0];
                    n_sat     = w_sat[DW];
                    w_alu_req = '{start: 1'b1, op: tli_pkg::ALU_MUL};
                    w_alu_a   = r_wmag;
                    w_alu_b   = w_dy2[tli_pkg::MAG_W-1:0];
                    n_pneg    = r_wneg ^ w_dy2[tli_pkg::MAG_W];
                    n_state   = tli_pkg::ST_MUL2;
                end
            end
            tli_pkg::ST_MUL2: begin
                if (w_alu_rsp.done) begin
                    n_y2o   = w_sat[DW-1:0];
                    n_done  = 1'b1;
                    n_state = tli_pkg::ST_IDLE;
                    if (r_sat || w_sat[DW]) begin
                        n_statuso = tli_pkg::STATUS_SATURATED;
                    end else if (r_ext) begin
                        n_statuso = tli_pkg::STATUS_EXTRAP;
                    end else begin
                        n_statuso = tli_pkg::STATUS_OK;
                    end
                end
            end
            default: begin
                n_state = tli_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tli_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_n       <= n_n;
        r_i       <= n_i;
        r_j       <= n_j;
        r_ext     <= n_ext;
        r_row_a   <= n_row_a;
        r_row_b   <= n_row_b;
        r_wneg    <= n_wneg;
        r_pneg    <= n_pneg;
        r_wmag    <= n_wmag;
        r_sat     <= n_sat;
        r_y1o     <= n_y1o;
        r_y2o     <= n_y2o;
        r_statuso <= n_statuso;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == tli_pkg::REG_ENTRY_COUNT)) begin
            r_entry_count <= pwdata[tli_pkg::ENTRY_COUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tli_pkg::REG_ENTRY_COUNT) ? DW'(r_entry_count) : '0;

    assign o_done      = r_done;
    assign o_y1_result = r_y1o;
    assign o_y2_result = r_y2o;
    assign o_status    = r_statuso;

    a_alu_in_math: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_rsp.busy |-> (r_state == tli_pkg::ST_DIV || r_state == tli_pkg::ST_MUL1 ||
                            r_state == tli_pkg::ST_MUL2))
        else $error("shared unit running outside the arithmetic states");

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tli_pkg::ST_SRCH) |-> (r_i < r_j && r_j <= r_n))
        else $error("search bounds out of order");

    a_small_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == tli_pkg::STATUS_TOO_SMALL) |->
        (o_y1_result == '0 && o_y2_result == '0))
        else $error("small table result not zero");

    a_query_ends_with_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("query finished without a result word");

endmodule
